// File: hw/rtl/emod_pkg.sv
// Package for the element-wise integer modulo unit.
// Holds the payload and pipeline types, register indexes and width helpers.
// No dependencies.
package emod_pkg;

	// Datapath width of the divider chain; element widths above it are cut.
	localparam int DATA_WIDTH = 64;
	// Fixed width of the dividend, divisor and remainder fields.
	localparam int WORD_W = 64;
	// Width of an element bit count (holds WORD_W itself).
	localparam int WIDTH_W = $clog2(WORD_W + 1);
	// Width of a bit index into a field word.
	localparam int BIT_INDEX_W = $clog2(WORD_W);
	// One restoring division step per cell, one cell per magnitude bit.
	localparam int NUM_CELLS = DATA_WIDTH;
	// Configuration register widths.
	localparam int ETYPE_W = 3;
	localparam int CFG_DATA_W = ETYPE_W;
	localparam int CFG_INDEX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_TYPE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TRUNCATED_MODE = 1'd1;

	// Bit of element_type that marks an unsigned element.
	localparam int ETYPE_UNSIGNED_BIT = 2;

	// Input transaction payload.
	typedef struct packed {
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
		logic last_element;
	} in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [WORD_W-1:0] remainder;
		logic divide_by_zero;
		logic last_result;
	} out_t;

	// Per-element control that rides alongside the divider chain.
	typedef struct packed {
		logic dz;
		logic last;
		logic neg_a;
		logic neg_b;
		logic floor_en;
	} side_t;

	// Data handed from one divider cell to the next.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH-1:0] num;
		logic [DATA_WIDTH-1:0] dvs;
		side_t side;
	} cell_t;

	// Element bit count for a width code (8 << code), limited to DATA_WIDTH.
	function automatic logic [WIDTH_W-1:0] elem_width(input logic [1:0] code);
		logic [WIDTH_W-1:0] w;
		w = WIDTH_W'(8) << code;
		if (w > WIDTH_W'(DATA_WIDTH)) begin
			w = WIDTH_W'(DATA_WIDTH);
		end
		return w;
	endfunction

	// Mask of the low w bits of a field word.
	function automatic logic [WORD_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
		logic [WORD_W-1:0] m;
		if (w >= WIDTH_W'(WORD_W)) begin
			m = '1;
		end else begin
			m = (WORD_W'(1) << w) - WORD_W'(1);
		end
		return m;
	endfunction

endpackage

// File: hw/rtl/emod_prep.sv
// Operand preparation stage: masking, sign handling and magnitudes.
// Feeds the first divider cell. Depends on emod_pkg.
module emod_prep (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  emod_pkg::in_t                     data_in,
	input  logic [emod_pkg::ETYPE_W-1:0]      element_type,
	input  logic                              truncated_mode,
	output logic                              valid_s1,
	output emod_pkg::cell_t                   data_s1
);

	logic [emod_pkg::WIDTH_W-1:0] w;
	logic [emod_pkg::WORD_W-1:0]  mask;
	logic [emod_pkg::BIT_INDEX_W-1:0] sidx;
	logic                         is_signed;
	logic [emod_pkg::WORD_W-1:0]  a_m;
	logic [emod_pkg::WORD_W-1:0]  b_m;
	logic                         na;
	logic                         nb;
	logic [emod_pkg::WORD_W-1:0]  sa;
	logic [emod_pkg::WORD_W-1:0]  sb;
	logic [emod_pkg::WORD_W-1:0]  ma;
	logic [emod_pkg::WORD_W-1:0]  mb;
	emod_pkg::cell_t              nxt;

	// Mask the operands to the element width and take their magnitudes.
	always_comb begin
		w = emod_pkg::elem_width(element_type[1:0]);
		mask = emod_pkg::width_mask(w);
		sidx = emod_pkg::BIT_INDEX_W'(w - emod_pkg::WIDTH_W'(1));
		is_signed = !element_type[emod_pkg::ETYPE_UNSIGNED_BIT];
		a_m = data_in.dividend & mask;
		b_m = data_in.divisor & mask;
		na = is_signed && a_m[sidx];
		nb = is_signed && b_m[sidx];
		sa = na ? (a_m | ~mask) : a_m;
		sb = nb ? (b_m | ~mask) : b_m;
		ma = na ? (emod_pkg::WORD_W'(0) - sa) : sa;
		mb = nb ? (emod_pkg::WORD_W'(0) - sb) : sb;

		nxt.rem = '0;
		nxt.num = ma[emod_pkg::DATA_WIDTH-1:0];
		nxt.dvs = mb[emod_pkg::DATA_WIDTH-1:0];
		nxt.side.dz = (b_m == '0);
		nxt.side.last = data_in.last_element;
		nxt.side.neg_a = na;
		nxt.side.neg_b = nb;
		nxt.side.floor_en = is_signed && !truncated_mode;
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: hw/rtl/emod_cell.sv
// One restoring division cell: brings down one dividend bit per step.
// Identical cells form the divider chain. Depends on emod_pkg.
module emod_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  emod_pkg::cell_t data_in,
	output logic            valid_q,
	output emod_pkg::cell_t data_q
);

	logic [emod_pkg::DATA_WIDTH:0]   trial;
	logic [emod_pkg::DATA_WIDTH:0]   diff;
	emod_pkg::cell_t                 nxt;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		trial = {data_in.rem, data_in.num[emod_pkg::DATA_WIDTH-1]};
		diff = trial - {1'b0, data_in.dvs};
		nxt = data_in;
		nxt.num = data_in.num << 1;
		if (trial >= {1'b0, data_in.dvs}) begin
			nxt.rem = diff[emod_pkg::DATA_WIDTH-1:0];
		end else begin
			nxt.rem = trial[emod_pkg::DATA_WIDTH-1:0];
		end
	end

	// Cell valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Cell payload handed to the next neighbor.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

// File: hw/rtl/emod_fix.sv
// Result stage: restores the sign, applies the floored correction,
// handles a zero divisor and holds the output register. Depends on emod_pkg.
module emod_fix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  emod_pkg::cell_t data_in,
	output logic            out_valid_q,
	output emod_pkg::out_t  out_q
);

	logic [emod_pkg::WORD_W-1:0] r;
	logic [emod_pkg::WORD_W-1:0] m;
	logic [emod_pkg::WORD_W-1:0] op_a;
	logic [emod_pkg::WORD_W-1:0] op_b;
	logic                        flip;
	emod_pkg::out_t              nxt;

	// The signed result folds into a single subtraction:
	// plain r, negated r, divisor minus r, or r minus divisor.
	always_comb begin
		r = emod_pkg::WORD_W'(data_in.rem);
		m = emod_pkg::WORD_W'(data_in.dvs);
		flip = data_in.side.floor_en && (r != '0) &&
			(data_in.side.neg_a != data_in.side.neg_b);
		if (flip && data_in.side.neg_a) begin
			op_a = m;
			op_b = r;
		end else if (flip) begin
			op_a = r;
			op_b = m;
		end else if (data_in.side.neg_a) begin
			op_a = '0;
			op_b = r;
		end else begin
			op_a = r;
			op_b = '0;
		end
		nxt.remainder = data_in.side.dz ? '0 : (op_a - op_b);
		nxt.divide_by_zero = data_in.side.dz;
		nxt.last_result = data_in.side.last;
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_in;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= nxt;
		end
	end

endmodule

// File: hw/rtl/elementwise_integer_modulo_unit.sv
// Element-wise integer modulo unit, top level.
// A transaction passes through the preparation stage, which registers at the
// accepting edge, then one cell per bit of the 64-cell divider chain, then the
// result stage. One transaction is accepted per cycle while in_stall is low.
// Reset (arst_n low) empties the pipeline and clears both registers to 0.
module elementwise_integer_modulo_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [emod_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [emod_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  emod_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output emod_pkg::out_t                       out_data
);

	logic [emod_pkg::ETYPE_W-1:0] element_type_q;
	logic                         truncated_mode_q;
	logic                         en;
	logic                         chain_valid [0:emod_pkg::NUM_CELLS];
	emod_pkg::cell_t              chain_data  [0:emod_pkg::NUM_CELLS];

	// The whole pipeline moves unless a finished result is held back.
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_type_q <= '0;
			truncated_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				emod_pkg::CFG_ELEMENT_TYPE: begin
					element_type_q <= cfg_data;
				end
				emod_pkg::CFG_TRUNCATED_MODE: begin
					truncated_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Operand preparation.
	emod_prep u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_in       (in_valid),
		.data_in        (in_data),
		.element_type   (element_type_q),
		.truncated_mode (truncated_mode_q),
		.valid_s1       (chain_valid[0]),
		.data_s1        (chain_data[0])
	);

	// Divider chain, one dividend bit per cell.
	for (genvar i = 0; i < emod_pkg::NUM_CELLS; i++) begin : g_cell
		emod_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (chain_valid[i]),
			.data_in  (chain_data[i]),
			.valid_q  (chain_valid[i+1]),
			.data_q   (chain_data[i+1])
		);
	end

	// Sign fix-up and output register.
	emod_fix u_fix (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (chain_valid[emod_pkg::NUM_CELLS]),
		.data_in     (chain_data[emod_pkg::NUM_CELLS]),
		.out_valid_q (out_valid),
		.out_q       (out_data)
	);

endmodule

// File: sim/tb_elementwise_integer_modulo_unit.sv
// Self-checking testbench for the element-wise integer modulo unit.
// Drives random and directed operand pairs under every element type and mode and checks each
// remainder against an in-bench predictor. Depends on emod_pkg and the unit's RTL.
module tb_elementwise_integer_modulo_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [emod_pkg::ETYPE_W-1:0] {
		ET_INT8, ET_INT16, ET_INT32, ET_INT64,
		ET_UINT8, ET_UINT16, ET_UINT32, ET_UINT64
	} elem_type_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 100;
	localparam int IDLE_PERCENT = 13;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [emod_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [emod_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	emod_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	emod_pkg::out_t out_data;

	// Shadow copy of the configuration registers.
	elem_type_t cur_etype;
	logic cur_trunc;

	// Remainders predicted for accepted transactions, oldest first.
	emod_pkg::out_t pending_remainders[$];
	int mismatch_count;
	int cycle_count;
	// While set, neither side idles.
	bit quiet;

	elementwise_integer_modulo_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Predict one result from the operands and the current register values.
	function automatic emod_pkg::out_t predict_remainder(emod_pkg::in_t item,
			logic [emod_pkg::ETYPE_W-1:0] etype, logic trunc);
		int unsigned w;
		logic [63:0] mask, a, b, sa, sb, ma, mb, r, res;
		logic na, nb;
		emod_pkg::out_t o;
		w = 8 << etype[1:0];
		if (w > emod_pkg::DATA_WIDTH) begin
			w = emod_pkg::DATA_WIDTH;
		end
		mask = (w >= 64) ? '1 : (64'd1 << w) - 64'd1;
		a = item.dividend & mask;
		b = item.divisor & mask;
		res = '0;
		o.divide_by_zero = 1'b0;
		if (b == 64'd0) begin
			o.divide_by_zero = 1'b1;
		end else if (etype[emod_pkg::ETYPE_UNSIGNED_BIT]) begin
			res = a % b;
		end else begin
			sa = a[w-1] ? (a | ~mask) : a;
			sb = b[w-1] ? (b | ~mask) : b;
			na = sa[63];
			nb = sb[63];
			ma = na ? 64'd0 - sa : sa;
			mb = nb ? 64'd0 - sb : sb;
			r = ma % mb;
			res = na ? 64'd0 - r : r;
			// Floored mode moves a nonzero remainder over to the divisor's sign.
			if (!trunc && r != 64'd0 && na != nb) begin
				res = res + sb;
			end
		end
		o.remainder = res;
		o.last_result = item.last_element;
		return o;
	endfunction

	// Operand with a random upper part and a low part biased toward edge values.
	function automatic logic [63:0] pick_operand(logic [emod_pkg::ETYPE_W-1:0] etype);
		int unsigned w;
		logic [63:0] raw, mask, v;
		raw = {$urandom, $urandom};
		w = 8 << etype[1:0];
		if (w > emod_pkg::DATA_WIDTH) begin
			w = emod_pkg::DATA_WIDTH;
		end
		mask = (w >= 64) ? '1 : (64'd1 << w) - 64'd1;
		case ($urandom_range(0, 11))
			0: v = 64'd0;
			1: v = 64'd1;
			2: v = mask;
			3: v = 64'd1 << (w - 1);
			4: v = mask >> 1;
			5: v = 64'($urandom_range(0, 15));
			6: v = mask - 64'($urandom_range(0, 15));
			default: v = raw;
		endcase
		return (raw & ~mask) | (v & mask);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Write one configuration register and track it in the shadow copy.
	task automatic write_reg(logic [emod_pkg::CFG_INDEX_W-1:0] idx,
			logic [emod_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == emod_pkg::CFG_ELEMENT_TYPE) begin
			cur_etype = elem_type_t'(value);
		end else if (idx == emod_pkg::CFG_TRUNCATED_MODE) begin
			cur_trunc = value[0];
		end
		@(posedge clk);
	endtask

	task automatic set_mode(elem_type_t etype, logic trunc);
		write_reg(emod_pkg::CFG_ELEMENT_TYPE, etype);
		write_reg(emod_pkg::CFG_TRUNCATED_MODE, emod_pkg::CFG_DATA_W'(trunc));
	endtask

	// Offer one operand pair and wait until the transaction is accepted.
	task automatic send_operands(logic [63:0] a, logic [63:0] b, logic last);
		emod_pkg::in_t item;
		bit taken;
		item.dividend = a;
		item.divisor = b;
		item.last_element = last;
		if (!quiet) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= item;
		// Inputs only move at rising edges, so the stall seen at the falling edge decides.
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pending_remainders.push_back(predict_remainder(item, cur_etype, cur_trunc));
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) begin
			send_operands(pick_operand(cur_etype), pick_operand(cur_etype),
				1'($urandom_range(0, 1)));
		end
	endtask

	// Hold off new input until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_remainders.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Reset values: int8 with floored remainders, including upper garbage bits.
	task automatic test_int8_floor_defaults();
		send_operands(64'hF9, 64'd3, 1'b0);
		send_operands(64'd7, 64'hFD, 1'b1);
		send_operands(64'hDEAD_BEEF_0000_0080, 64'h1234_5678_9ABC_DEFF, 1'b0);
		send_operands(64'hFFFF_FFFF_FFFF_FF05, 64'h0000_0000_0000_AB00, 1'b1);
		send_operands(64'h80, 64'h7F, 1'b0);
		send_operands(64'd6, 64'hFD, 1'b0);
		send_operands(64'h7F, 64'h80, 1'b1);
		drain_results();
	endtask

	// Full-width signed edges in both modes.
	task automatic test_int64_edges();
		set_mode(ET_INT64, 1'b1);
		send_operands(64'h8000_0000_0000_0000, '1, 1'b0);
		send_operands(64'hFFFF_FFFF_FFFF_FFF9, 64'd3, 1'b1);
		send_operands(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0);
		send_operands('1, 64'd0, 1'b1);
		send_operands(64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
		drain_results();
		set_mode(ET_INT64, 1'b0);
		send_operands(64'h8000_0000_0000_0000, '1, 1'b1);
		send_operands(64'hFFFF_FFFF_FFFF_FFF9, 64'd3, 1'b0);
		send_operands(64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		drain_results();
	endtask

	// Unsigned types at full width and with ignored upper bits.
	task automatic test_unsigned_edges();
		set_mode(ET_UINT64, 1'b0);
		send_operands('1, 64'd3, 1'b0);
		send_operands('1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		send_operands(64'd5, 64'd0, 1'b0);
		drain_results();
		set_mode(ET_UINT8, 1'b1);
		send_operands(64'hFFFF_FF05, 64'h1234_5603, 1'b1);
		send_operands(64'hFF, 64'hFF00, 1'b0);
		drain_results();
	endtask

	// Random operands under every element type and both modes.
	task automatic test_all_settings();
		for (int e = 0; e < 8; e++) begin
			for (int t = 0; t < 2; t++) begin
				set_mode(elem_type_t'(e), 1'(t));
				send_random(60);
				drain_results();
			end
		end
	endtask

	// A long stream with neither side idling.
	task automatic test_quiet_stream();
		set_mode(elem_type_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		quiet = 1'b1;
		send_random(300);
		drain_results();
		quiet = 1'b0;
	endtask

	// The sender stops midway until the pipeline is empty, then carries on.
	task automatic test_pause_midstream();
		set_mode(elem_type_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		send_random(100);
		drain_results();
		send_random(100);
		drain_results();
	endtask

	// Receiver stalls at random, except during the quiet stretch.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Compare every accepted result with the oldest prediction.
	always @(negedge clk) begin
		emod_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_remainders.size() == 0) begin
				report_mismatch("unexpected result", out_data.remainder, '0);
			end else begin
				want = pending_remainders.pop_front();
				if (out_data.remainder !== want.remainder) begin
					report_mismatch("remainder", out_data.remainder, want.remainder);
				end
				if (out_data.divide_by_zero !== want.divide_by_zero) begin
					report_mismatch("divide_by_zero", 64'(out_data.divide_by_zero),
						64'(want.divide_by_zero));
				end
				if (out_data.last_result !== want.last_result) begin
					report_mismatch("last_result", 64'(out_data.last_result),
						64'(want.last_result));
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cur_etype = ET_INT8;
		cur_trunc = 1'b0;
		mismatch_count = 0;
		quiet = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_int8_floor_defaults();
		test_int64_edges();
		test_unsigned_edges();
		test_all_settings();
		test_quiet_stream();
		test_pause_midstream();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_remainders.size() != 0) begin
			report_mismatch("results never arrived", 64'(pending_remainders.size()), '0);
		end
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/emod_pkg.sv
hw/rtl/emod_prep.sv
hw/rtl/emod_cell.sv
hw/rtl/emod_fix.sv
hw/rtl/elementwise_integer_modulo_unit.sv
sim/tb_elementwise_integer_modulo_unit.sv
